>>> src/dpfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpfm_pkg: shared constants and types of the frame manager
// Table geometry, field widths, status codes.
// ----------------------------------------------------------------------------
package dpfm_pkg;
   // table geometry, each a power of two; page bits must lie inside vaddr
   localparam int NUM_PROC   = 4;
   localparam int PAGE_BYTES = 4096;
   localparam int VPAGES     = 1024;

   localparam int NUM_FRAMES_DEF = 64;

   localparam int PROC_W   = 2;
   localparam int VADDR_W  = 22;
   localparam int STATUS_W = 2;
   localparam int FRAME_W  = 6;
   localparam int VPAGE_W  = 10;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT     = 2'd0,
      ST_MAPPED  = 2'd1,
      ST_COW     = 2'd2,
      ST_NOFRAME = 2'd3
   } status_type;
endpackage
`default_nettype wire

>>> src/demand_paging_frame_manager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_frame_manager: page table and free-frame stack
// Per-process page tables in one memory, a frame stack, swap-out on empty.
// ----------------------------------------------------------------------------
// A hit passes through accept, decode and respond; a fault adds a write-back
// step before respond. Each waits in respond while rsp_tready is held low, and
// req_tready stays low until the response has gone. With no free frame a
// swap-out scan reads the table one entry a cycle from the start and stops at
// the first valid entry, the victim; when no entry is valid it reads the whole
// table and answers with no frame. After reset a clearing pass writes every
// table entry, one a cycle, while req_tready stays low. Table geometry comes
// from the package; frames leave the stack top first, so the top is count-1,
// and a swap-out does not push the victim frame but hands it straight to the
// faulting page.
module demand_paging_frame_manager #(
   parameter int NUM_FRAMES = dpfm_pkg::NUM_FRAMES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // proc_id[1:0], vaddr[23:2], write_req[24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // status[1:0], frame[7:2], did_swap[8],
                                        // victim_proc[10:9], victim_page[20:11],
                                        // victim_frame[26:21]
);
   import dpfm_pkg::*;

   localparam int N_ENT  = NUM_PROC * VPAGES;
   localparam int PR_W   = $clog2(NUM_PROC);
   localparam int PG_W   = $clog2(VPAGES);
   localparam int SH_W   = $clog2(PAGE_BYTES);
   localparam int IDX_W  = PR_W + PG_W;
   localparam int PTR_W  = IDX_W + 1;
   localparam int FN_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
   localparam int ENT_W  = 3 + FN_W;
   localparam int B_VAL  = ENT_W - 1;
   localparam int B_MOD  = ENT_W - 2;
   localparam int B_SWP  = ENT_W - 3;
   localparam int WR_BIT = PROC_W + VADDR_W;
   localparam int PG_LO  = PROC_W + SH_W;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DEC   = 6'b000100,
      S_SCAN  = 6'b001000,
      S_POP   = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   // entry: {valid, modified, swapped, frame}
   logic [ENT_W-1:0] table_mem [N_ENT];

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             wr_ff, wr_in;
   logic             cow_ff, cow_in;
   logic [ENT_W-1:0] ent_ff, ent_in;
   logic [ENT_W-1:0] rd_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   status_type       st_ff, st_in;
   logic [FN_W-1:0]  frm_ff, frm_in;
   logic             swap_ff, swap_in;
   logic [IDX_W-1:0] vidx_ff, vidx_in;
   logic [FN_W-1:0]  vfrm_ff, vfrm_in;
   logic [NUM_FRAMES-1:0] swap_marks_ff, marks_in;

   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] vic_addr;
   logic [IDX_W-1:0] rd_addr;
   logic             we;
   logic [IDX_W-1:0] wa;
   logic [ENT_W-1:0] wd;

   assign req_idx  = {req_tdata[PR_W-1:0], req_tdata[PG_LO+PG_W-1:PG_LO]};
   assign vic_addr = ptr_ff[IDX_W-1:0] - 1'b1;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (we) table_mem[wa] <= wd;
      rd_ff <= table_mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      wr_in    = wr_ff;
      cow_in   = cow_ff;
      ent_in   = ent_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      frm_in   = frm_ff;
      swap_in  = swap_ff;
      vidx_in  = vidx_ff;
      vfrm_in  = vfrm_ff;
      marks_in = swap_marks_ff;
      rd_addr  = ptr_ff[IDX_W-1:0];
      we       = 1'b0;
      wa       = ptr_ff[IDX_W-1:0];
      wd       = '0;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == PTR_W'(N_ENT - 1)) begin
               ptr_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = req_idx;
            if (req_tvalid) begin
               idx_in   = req_idx;
               wr_in    = req_tdata[WR_BIT];
               swap_in  = 1'b0;
               vidx_in  = '0;
               vfrm_in  = '0;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            ent_in = rd_ff;
            cow_in = rd_ff[B_VAL];
            frm_in = rd_ff[FN_W-1:0];
            st_in  = ST_HIT;
            if (!rd_ff[B_VAL] || (wr_ff && !rd_ff[B_MOD])) begin
               if (cnt_ff == '0) begin
                  ptr_in = '0;
                  state_in = S_SCAN;
               end else state_in = S_POP;
            end else state_in = S_RESP;
         end
         S_SCAN: begin
            // rd_ff holds entry ptr_ff-1 once ptr_ff is past zero
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff != '0 && rd_ff[B_VAL]) begin
               we = 1'b1;
               wa = vic_addr;
               wd = rd_ff;
               wd[B_VAL] = 1'b0;
               wd[B_SWP] = 1'b1;
               swap_in = 1'b1;
               vidx_in = vic_addr;
               vfrm_in = rd_ff[FN_W-1:0];
               marks_in[rd_ff[FN_W-1:0]] = 1'b1;
               if (vic_addr == idx_ff) begin
                  ent_in[B_VAL] = 1'b0;
                  ent_in[B_SWP] = 1'b1;
               end
               state_in = S_POP;
            end else if (ptr_ff == PTR_W'(N_ENT)) state_in = S_POP;
         end
         S_POP: begin
            state_in = S_RESP;
            if (cnt_ff != '0 || swap_ff) begin
               we = 1'b1;
               wa = idx_ff;
               wd = ent_ff;
               if (swap_ff) wd[FN_W-1:0] = vfrm_ff;
               else begin
                  wd[FN_W-1:0] = FN_W'(cnt_ff - 1'b1);
                  cnt_in = cnt_ff - 1'b1;
               end
               if (cow_ff) begin
                  wd[B_MOD] = 1'b1;
                  st_in = ST_COW;
               end else begin
                  wd[B_VAL] = 1'b1;
                  st_in = ST_MAPPED;
               end
               frm_in = wd[FN_W-1:0];
            end else st_in = ST_NOFRAME;
         end
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         idx_ff        <= '0;
         wr_ff         <= 1'b0;
         cow_ff        <= 1'b0;
         ent_ff        <= '0;
         cnt_ff        <= CNT_W'(NUM_FRAMES);
         st_ff         <= ST_HIT;
         frm_ff        <= '0;
         swap_ff       <= 1'b0;
         vidx_ff       <= '0;
         vfrm_ff       <= '0;
         swap_marks_ff <= '0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         idx_ff        <= idx_in;
         wr_ff         <= wr_in;
         cow_ff        <= cow_in;
         ent_ff        <= ent_in;
         cnt_ff        <= cnt_in;
         st_ff         <= st_in;
         frm_ff        <= frm_in;
         swap_ff       <= swap_in;
         vidx_ff       <= vidx_in;
         vfrm_ff       <= vfrm_in;
         swap_marks_ff <= marks_in;
      end
   end

   assign rsp_tdata = {5'd0, FRAME_W'(vfrm_ff), VPAGE_W'(vidx_ff[PG_W-1:0]),
                       PROC_W'(vidx_ff[IDX_W-1:PG_W]), swap_ff, FRAME_W'(frm_ff), st_ff};

   property p_busy;
      @(posedge clock) disable iff (reset) (state_ff == S_SCAN) |-> !req_tready;
   endproperty
   a_busy: assert property (p_busy) else $error("ready during scan");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= NUM_FRAMES) else $error("free count overflow");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped or changed");
   a_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
endmodule
`default_nettype wire
